[hdl/pps_pkg.sv]
`default_nettype none

package pps_pkg;

    localparam int NUM_STAGES = 64;
    localparam int VALUE_BITS = 16;

    localparam int IDX_BITS = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int CNT_BITS = $clog2(NUM_STAGES + 1);
    localparam int BIT_BITS = $clog2(VALUE_BITS);

    localparam logic OP_VALUE = 1'b0;
    localparam logic OP_EOS   = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] candidate;
    } in_item_t;

    typedef struct packed {
        logic [15:0] prime;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic rd;
        logic div_init;
        logic div_step;
        logic next;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_eos;
        logic in_small;
        logic scan_end;
        logic div_last;
        logic divisible;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[hdl/pps_ctrl.sv]
`default_nettype none

module pps_ctrl
    import pps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cand_valid,
    output logic         cand_stall,
    input  wire status_t st,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_DIV,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cand_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cand_valid)
                begin
                    if (st.in_eos)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (!st.in_small)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (st.scan_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.divisible)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.next   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/pps_datapath.sv]
`default_nettype none

module pps_datapath
    import pps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t cand,
    input  wire cmd_t     cmd,
    output status_t       st,
    output logic          res_valid,
    input  wire logic     res_stall,
    output out_item_t     res
);

    logic [VALUE_BITS-1:0] stage_mem [NUM_STAGES];
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic [CNT_BITS-1:0]   used_reg;
    logic [CNT_BITS-1:0]   idx_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] dividend_reg;
    logic [VALUE_BITS-1:0] divisor_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [BIT_BITS-1:0]   bit_reg;
    logic                  res_valid_reg;
    out_item_t             res_reg;

    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS:0]   rem_shift;
    logic [VALUE_BITS:0]   rem_sub;
    logic [VALUE_BITS-1:0] rem_next;
    logic                  full;

    assign in_value = VALUE_BITS'(cand.candidate);

    // one quotient bit per cycle, restoring form
    assign rem_shift = {rem_reg, dividend_reg[VALUE_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor_reg};
    assign rem_next  = rem_sub[VALUE_BITS] ? rem_shift[VALUE_BITS-1:0]
                                           : rem_sub[VALUE_BITS-1:0];

    assign full = (used_reg == CNT_BITS'(NUM_STAGES));

    assign st.in_eos    = (cand.op == OP_EOS);
    assign st.in_small  = (in_value < VALUE_BITS'(2));
    assign st.scan_end  = (idx_reg == used_reg);
    assign st.div_last  = (bit_reg == '0);
    assign st.divisible = (rem_reg == '0);
    assign st.out_free  = !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= stage_mem[idx_reg[IDX_BITS-1:0]];
        end
        if (cmd.emit && !full)
        begin
            stage_mem[used_reg[IDX_BITS-1:0]] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= in_value;
        end
        if (cmd.div_init)
        begin
            divisor_reg  <= rd_data_reg;
            dividend_reg <= value_reg;
            rem_reg      <= '0;
            bit_reg      <= BIT_BITS'(VALUE_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[VALUE_BITS-2:0], 1'b0};
            rem_reg      <= rem_next;
            bit_reg      <= bit_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            res_reg.prime      <= 16'(value_reg);
            res_reg.table_full <= full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                used_reg <= '0;
            end
            else if (cmd.emit && !full)
            begin
                used_reg <= used_reg + 1'b1;
            end

            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.next)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/pipelined_prime_sieve.sv]
// channel  direction  handshake               payload
// cand     in         cand_valid/cand_stall   in_item_t  {op, candidate}
// res      out        res_valid/res_stall     out_item_t {prime, table_full}
//
// a candidate walks the stored primes one at a time; each stored prime takes a memory
// read, a divisor load, a bit-serial remainder and a check; a survivor is emitted once
// every stored prime is tested, and a candidate is dropped at the first prime that divides
// it; end of stream clears the fill count and a value below two is dropped, both in idle
// rst_n clears the fill count; stored primes need no clearing
// res holds its result while res_stall is high; a new candidate is taken meanwhile
`default_nettype none

module pipelined_prime_sieve
    import pps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cand_valid,
    output logic           cand_stall,
    input  wire in_item_t  cand,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res
);

    cmd_t    cmd;
    status_t st;

    pps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .st         (st),
        .cmd        (cmd)
    );

    pps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cand      (cand),
        .cmd       (cmd),
        .st        (st),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

[hdl/pps_checker.sv]
`default_nettype none

module pps_checker
    import pps_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cand_valid,
    input wire logic      cand_stall,
    input wire in_item_t  cand,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire out_item_t res
);

    // a stalled result stays
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result dropped or changed");

    // only values of two or more survive
    a_res_min: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.prime >= 16'd2)
        else $error("result below two");

    // a result does not rise right after a candidate is taken; the scan comes first
    a_no_fast_res: assert property (@(posedge clk) disable iff (!rst_n)
        cand_valid && !cand_stall |=> !$rose(res_valid))
        else $error("result came right after a transfer");

    // end of stream finishes at once
    a_eos_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cand_valid && !cand_stall && cand.op == OP_EOS |=> !cand_stall)
        else $error("end of stream left the block busy");

endmodule

bind pipelined_prime_sieve pps_checker u_pps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);

`default_nettype wire
